@@ rtl/ccvm_pkg.sv @@
// shared types and constants for the cascaded cv mixer with clamp
`default_nettype none

package ccvm_pkg;

    localparam int unsigned CHAN_W  = 3;
    localparam int unsigned MV_W    = 15;
    localparam int unsigned MAG_W   = 15;
    localparam int unsigned PROD_W  = 30;
    localparam int unsigned QUOT_W  = 17;
    localparam int unsigned SUM_W   = 18;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;

    localparam logic signed [MV_W-1:0]  FULL_SCALE_MV = 15'sd10000;
    localparam logic signed [MV_W:0]    KNOB_OFFSET   = 16'sd10000;
    localparam logic signed [SUM_W-1:0] SUM_MAX       = 18'sd10000;
    localparam logic signed [SUM_W-1:0] SUM_MIN       = -18'sd10000;

    // floor(x / 10000) = (x * RECIP_10K) >> RECIP_SHIFT for x below 2^30
    localparam logic [PROD_W-1:0] RECIP_10K   = 30'd879609303;
    localparam int unsigned       RECIP_SHIFT = 43;

    localparam logic [CFG_IDX_W-1:0] REG_ATTEN_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_OUTPUT = 1'b1;

    typedef enum logic [1:0] {
        OP_OFF = 2'b00,
        OP_ADD = 2'b01,
        OP_SUB = 2'b11
    } op_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        chan;
        logic signed [MV_W-1:0]   sample;
        logic signed [MV_W-1:0]   knob;
        logic [1:0]               op;
        logic [1:0]               mode;
        logic                     in_pl;
        logic                     out_pl;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [QUOT_W-1:0] mag;
        logic              neg;
        op_t               eff;
        logic              out_pl;
    } part_t;

endpackage

`default_nettype wire

@@ rtl/ccvm_part.sv @@
// four-stage pipeline that forms one channel's scaled contribution
`default_nettype none

module ccvm_part
    import ccvm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  attenuator_mode,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output part_t      out_part
);

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        op_t               eff;
        logic              neg;
        logic              in_pl;
        logic              out_pl;
    } meta_t;

    logic              s1_valid_reg, s1_valid_next;
    item_t             s1_item_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic [MAG_W-1:0]  s2_a_reg, s2_b_reg;
    meta_t             s2_meta_reg;
    logic              s3_valid_reg, s3_valid_next;
    logic [PROD_W-1:0] s3_prod_reg;
    meta_t             s3_meta_reg;
    logic              s4_valid_reg, s4_valid_next;
    part_t             s4_part_reg;

    logic en1, en2, en3, en4;

    op_t               eff;
    logic              op_pos, mode_pos;
    logic [MAG_W-1:0]  sample_mag, knob_mag, k_mag;
    logic signed [MV_W:0] k_val, k_abs;
    logic [MAG_W-1:0]  a_next, b_next;
    meta_t             meta_next;
    logic [2*PROD_W-1:0] recip_full;
    logic [QUOT_W-1:0] q10, q_next;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign s1_valid_next = en1 ? in_valid     : s1_valid_reg;
    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = en4 ? s3_valid_reg : s4_valid_reg;

    // mode limiting, then magnitudes and sign of the product
    always_comb
    begin
        op_pos   = (s1_item_reg.op == OP_ADD);
        mode_pos = (s1_item_reg.mode == 2'b01);
        if (s1_item_reg.op[1])
        begin
            eff = mode_pos ? OP_OFF : OP_SUB;
        end
        else if (op_pos)
        begin
            eff = s1_item_reg.mode[1] ? OP_SUB : OP_ADD;
        end
        else
        begin
            eff = OP_OFF;
        end

        sample_mag = s1_item_reg.sample[MV_W-1] ? MAG_W'(-s1_item_reg.sample)
                                                : MAG_W'(s1_item_reg.sample);
        knob_mag   = s1_item_reg.knob[MV_W-1] ? MAG_W'(-s1_item_reg.knob)
                                              : MAG_W'(s1_item_reg.knob);
        k_val = attenuator_mode ? ((MV_W+1)'(s1_item_reg.knob) + KNOB_OFFSET)
                                : (MV_W+1)'(s1_item_reg.knob);
        k_abs = k_val[MV_W] ? -k_val : k_val;
        k_mag = k_abs[MAG_W-1:0];

        meta_next.chan   = s1_item_reg.chan;
        meta_next.eff    = eff;
        meta_next.in_pl  = s1_item_reg.in_pl;
        meta_next.out_pl = s1_item_reg.out_pl;
        if (s1_item_reg.in_pl)
        begin
            a_next = sample_mag;
            b_next = k_mag;
            meta_next.neg = s1_item_reg.sample[MV_W-1] ^ k_val[MV_W] ^ (eff == OP_SUB);
        end
        else
        begin
            a_next = knob_mag;
            b_next = MAG_W'(1);
            meta_next.neg = s1_item_reg.knob[MV_W-1] ^ (eff == OP_SUB);
        end
        if (eff == OP_OFF)
        begin
            a_next = '0;
        end
    end

    // plugged inputs divide by 10000 through the reciprocal, halved again for the 20 V span in attenuator mode
    always_comb
    begin
        recip_full = {{PROD_W{1'b0}}, s3_prod_reg} * {{PROD_W{1'b0}}, RECIP_10K};
        q10        = QUOT_W'(recip_full >> RECIP_SHIFT);
        if (!s3_meta_reg.in_pl)
        begin
            q_next = QUOT_W'(s3_prod_reg[MAG_W-1:0]);
        end
        else if (attenuator_mode)
        begin
            q_next = q10 >> 1;
        end
        else
        begin
            q_next = q10;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_item_reg <= in_item;
        end
        if (en2)
        begin
            s2_a_reg    <= a_next;
            s2_b_reg    <= b_next;
            s2_meta_reg <= meta_next;
        end
        if (en3)
        begin
            s3_prod_reg <= PROD_W'(s2_a_reg) * PROD_W'(s2_b_reg);
            s3_meta_reg <= s2_meta_reg;
        end
        if (en4)
        begin
            s4_part_reg.chan   <= s3_meta_reg.chan;
            s4_part_reg.mag    <= q_next;
            s4_part_reg.neg    <= s3_meta_reg.neg;
            s4_part_reg.eff    <= s3_meta_reg.eff;
            s4_part_reg.out_pl <= s3_meta_reg.out_pl;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_part  = s4_part_reg;

endmodule

`default_nettype wire

@@ rtl/cascaded_cv_mixer_with_clamp.sv @@
// top level: stream ports, configuration, running sum with clamp and result register
// Takes one channel request per clock while the output is not stalled and returns one
// result per request, in order. The channel contribution goes through a four-stage
// pipeline (input register, operand magnitudes, one multiply, a reciprocal multiply that
// divides by 10000) and then the result register, where the running sum is added and
// clamped to +/-10000 mV; that loop through one register sets the rate of one channel
// per clock. Each stage holds its request while the next is full, so requests keep
// entering while a finished result waits, until five requests are held. The user must
// write configuration only while the block is idle; the block does not enforce it.
`default_nettype none

module cascaded_cv_mixer_with_clamp
    import ccvm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // sample_mv[14:0], knob_mv[29:15], op[31:30], mode_sel[33:32],
    // in_plugged[34], out_plugged[35], zero fill [39:36]
    input  wire logic [39:0]           s_axis_tdata,
    // channel[2:0]
    input  wire logic [CHAN_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_mv[14:0], out_driven[15], effective_op[17:16], zero fill [23:18]
    output logic [23:0]                m_axis_tdata,
    // out_channel[2:0]
    output logic [CHAN_W-1:0]          m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    item_t in_item;
    logic  part_valid, part_ready;
    part_t part;

    logic attn_mode_reg, attn_mode_next;
    logic stop_reg, stop_next;
    logic res_valid_reg, res_valid_next;
    logic [CHAN_W-1:0]      out_chan_reg;
    logic signed [MV_W-1:0] out_mv_reg, running_sum_reg, running_sum_next;
    logic                   out_driven_reg;
    op_t                    out_eff_reg;

    logic signed [SUM_W-1:0] base, part_val, sum_raw;
    logic signed [MV_W-1:0]  sum_clamped;

    assign in_item.chan   = s_axis_tuser;
    assign in_item.sample = s_axis_tdata[14:0];
    assign in_item.knob   = s_axis_tdata[29:15];
    assign in_item.op     = s_axis_tdata[31:30];
    assign in_item.mode   = s_axis_tdata[33:32];
    assign in_item.in_pl  = s_axis_tdata[34];
    assign in_item.out_pl = s_axis_tdata[35];

    ccvm_part u_part (
        .clk             (clk),
        .rst_n           (rst_n),
        .attenuator_mode (attn_mode_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_item         (in_item),
        .out_valid       (part_valid),
        .out_ready       (part_ready),
        .out_part        (part)
    );

    assign part_ready = !res_valid_reg || m_axis_tready;

    always_comb
    begin
        base     = (part.chan == '0) ? '0 : SUM_W'(running_sum_reg);
        part_val = part.neg ? -SUM_W'({1'b0, part.mag}) : SUM_W'({1'b0, part.mag});
        sum_raw  = base + part_val;
        if (sum_raw > SUM_MAX)
        begin
            sum_clamped = FULL_SCALE_MV;
        end
        else if (sum_raw < SUM_MIN)
        begin
            sum_clamped = -FULL_SCALE_MV;
        end
        else
        begin
            sum_clamped = MV_W'(sum_raw);
        end

        running_sum_next = running_sum_reg;
        if (part_valid && part_ready)
        begin
            running_sum_next = (part.out_pl && stop_reg) ? '0 : sum_clamped;
        end

        res_valid_next = part_ready ? part_valid : res_valid_reg;
    end

    always_comb
    begin
        attn_mode_next = attn_mode_reg;
        stop_next      = stop_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTEN_MODE:     attn_mode_next = cfg_data[0];
                REG_STOP_ON_OUTPUT: stop_next      = cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attn_mode_reg   <= 1'b0;
            stop_reg        <= 1'b1;
            res_valid_reg   <= 1'b0;
            running_sum_reg <= '0;
        end
        else
        begin
            attn_mode_reg   <= attn_mode_next;
            stop_reg        <= stop_next;
            res_valid_reg   <= res_valid_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_valid && part_ready)
        begin
            out_chan_reg   <= part.chan;
            out_mv_reg     <= sum_clamped;
            out_driven_reg <= part.out_pl;
            out_eff_reg    <= part.eff;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {6'b0, out_eff_reg, out_driven_reg, out_mv_reg};
    assign m_axis_tuser  = out_chan_reg;

endmodule

`default_nettype wire

@@ rtl/ccvm_checker.sv @@
// port-level assertions for the mixer, bound to the top level
`default_nettype none

module ccvm_checker
    import ccvm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [23:0]       m_axis_tdata,
    input wire logic [CHAN_W-1:0] m_axis_tuser
);

    logic signed [MV_W-1:0] out_mv;
    logic [1:0]             out_eff;

    assign out_mv  = m_axis_tdata[14:0];
    assign out_eff = m_axis_tdata[17:16];

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_mv <= FULL_SCALE_MV) && (out_mv >= -FULL_SCALE_MV))
        else $error("output outside clamp range");

    a_restart_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == '0) && (out_eff == OP_OFF) |-> (out_mv == '0))
        else $error("channel zero with operation off did not restart at zero");

endmodule

bind cascaded_cv_mixer_with_clamp ccvm_checker u_ccvm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
